FILE: src/ppit_pkg.sv
// Shared constants, types and register indexes of the periodic point-in-triangle block.
package ppit_pkg;

  // Coordinate format.
  localparam int CW = 32;
  localparam int FB = 16;

  // Derived arithmetic widths.
  localparam int DW  = CW + 1;      // vertex and point differences
  localparam int PW  = 2 * DW;      // one signed product
  localparam int SW  = PW + 1;      // difference of two products
  localparam int MW  = SW - 2;      // magnitude of such a difference
  localparam int QW  = CW;          // quotient bits produced by the divider
  localparam int BW  = 31;          // box length register
  localparam int MGW = 16;          // margin register

  // Latencies in register stages.
  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = QW + 1;
  localparam int BACK_LAT  = 2;
  localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT + BACK_LAT;

  localparam int IN_TDATA_W  = 8 * CW;
  localparam int OUT_TDATA_W = 4 * CW;
  localparam int OUT_TUSER_W = 2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_BOX_X  = 2'd0,
    REG_BOX_Y  = 2'd1,
    REG_MARGIN = 2'd2,
    REG_NONE   = 2'd3
  } cfg_idx_e;

  // Values that travel beside the quotients through the divider.
  typedef struct packed {
    logic [CW-1:0] wrap_x;
    logic [CW-1:0] wrap_y;
    logic          degen;
    logic          neg_xi;
    logic          neg_eta;
  } ppit_side_t;

endpackage

FILE: src/ppit_front.sv
// Front pipeline: periodic shift, edge products, determinant and numerator magnitudes.
module ppit_front
  import ppit_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [CW-1:0]        px_i,
  input  logic [CW-1:0]        py_i,
  input  logic [CW-1:0]        x0_i,
  input  logic [CW-1:0]        y0_i,
  input  logic [CW-1:0]        x1_i,
  input  logic [CW-1:0]        y1_i,
  input  logic [CW-1:0]        x2_i,
  input  logic [CW-1:0]        y2_i,
  input  logic [BW-1:0]        lx_i,
  input  logic [BW-1:0]        ly_i,
  output logic [MW-1:0]        mag_xi_o,
  output logic [MW-1:0]        mag_eta_o,
  output logic [MW-1:0]        mag_det_o,
  output ppit_side_t           side_o
);

  // Stage 1: offsets from vertex 0.
  logic signed [DW-1:0] rx_q, ry_q, ax_q, ay_q, bx_q, by_q;
  logic        [CW-1:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q <= $signed({px_i[CW-1], px_i}) - $signed({x0_i[CW-1], x0_i});
      ry_q <= $signed({py_i[CW-1], py_i}) - $signed({y0_i[CW-1], y0_i});
      ax_q <= $signed({x1_i[CW-1], x1_i}) - $signed({x0_i[CW-1], x0_i});
      ay_q <= $signed({y1_i[CW-1], y1_i}) - $signed({y0_i[CW-1], y0_i});
      bx_q <= $signed({x2_i[CW-1], x2_i}) - $signed({x0_i[CW-1], x0_i});
      by_q <= $signed({y2_i[CW-1], y2_i}) - $signed({y0_i[CW-1], y0_i});
      px_q <= px_i;
      py_q <= py_i;
    end
  end

  // Stage 2: minimum image shift on each axis.
  logic signed [DW+1:0] two_rx, two_ry, lx_s, ly_s;
  logic                 hi_x, lo_x, hi_y, lo_y;
  logic signed [DW-1:0] rx_d, ry_d;
  logic        [CW-1:0] wx_d, wy_d;

  always_comb begin
    two_rx = $signed({rx_q[DW-1], rx_q, 1'b0});
    two_ry = $signed({ry_q[DW-1], ry_q, 1'b0});
    lx_s   = $signed({4'b0, lx_i});
    ly_s   = $signed({4'b0, ly_i});
    hi_x   = two_rx >= lx_s;
    lo_x   = two_rx < -lx_s;
    hi_y   = two_ry >= ly_s;
    lo_y   = two_ry < -ly_s;
    rx_d   = rx_q;
    ry_d   = ry_q;
    wx_d   = px_q;
    wy_d   = py_q;
    if (hi_x) begin
      rx_d = rx_q - $signed({2'b0, lx_i});
      wx_d = px_q - {1'b0, lx_i};
    end else if (lo_x) begin
      rx_d = rx_q + $signed({2'b0, lx_i});
      wx_d = px_q + {1'b0, lx_i};
    end
    if (hi_y) begin
      ry_d = ry_q - $signed({2'b0, ly_i});
      wy_d = py_q - {1'b0, ly_i};
    end else if (lo_y) begin
      ry_d = ry_q + $signed({2'b0, ly_i});
      wy_d = py_q + {1'b0, ly_i};
    end
  end

  logic signed [DW-1:0] rx2_q, ry2_q, ax2_q, ay2_q, bx2_q, by2_q;
  logic        [CW-1:0] wx2_q, wy2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx2_q <= rx_d;
      ry2_q <= ry_d;
      ax2_q <= ax_q;
      ay2_q <= ay_q;
      bx2_q <= bx_q;
      by2_q <= by_q;
      wx2_q <= wx_d;
      wy2_q <= wy_d;
    end
  end

  // Stage 3: the six cross products.
  logic signed [PW-1:0] p_aby_q, p_bay_q, p_byrx_q, p_bxry_q, p_axry_q, p_ayrx_q;
  logic        [CW-1:0] wx3_q, wy3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_aby_q  <= ax2_q * by2_q;
      p_bay_q  <= bx2_q * ay2_q;
      p_byrx_q <= by2_q * rx2_q;
      p_bxry_q <= bx2_q * ry2_q;
      p_axry_q <= ax2_q * ry2_q;
      p_ayrx_q <= ay2_q * rx2_q;
      wx3_q    <= wx2_q;
      wy3_q    <= wy2_q;
    end
  end

  // Stage 4: determinant and the two numerators.
  logic signed [SW-1:0] det_q, nxi_q, neta_q;
  logic        [CW-1:0] wx4_q, wy4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q  <= $signed({p_aby_q[PW-1], p_aby_q}) - $signed({p_bay_q[PW-1], p_bay_q});
      nxi_q  <= $signed({p_byrx_q[PW-1], p_byrx_q}) - $signed({p_bxry_q[PW-1], p_bxry_q});
      neta_q <= $signed({p_axry_q[PW-1], p_axry_q}) - $signed({p_ayrx_q[PW-1], p_ayrx_q});
      wx4_q  <= wx3_q;
      wy4_q  <= wy3_q;
    end
  end

  // Stage 5: magnitudes and quotient signs; all magnitudes stay below 2^MW.
  logic [SW-1:0] abs_det, abs_xi, abs_eta;

  always_comb begin
    abs_det = det_q[SW-1]  ? SW'(-det_q)  : SW'(det_q);
    abs_xi  = nxi_q[SW-1]  ? SW'(-nxi_q)  : SW'(nxi_q);
    abs_eta = neta_q[SW-1] ? SW'(-neta_q) : SW'(neta_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_det_o      <= abs_det[MW-1:0];
      mag_xi_o       <= abs_xi[MW-1:0];
      mag_eta_o      <= abs_eta[MW-1:0];
      side_o.wrap_x  <= wx4_q;
      side_o.wrap_y  <= wy4_q;
      side_o.degen   <= det_q == '0;
      side_o.neg_xi  <= nxi_q[SW-1] ^ det_q[SW-1];
      side_o.neg_eta <= neta_q[SW-1] ^ det_q[SW-1];
    end
  end

endmodule

FILE: src/ppit_div.sv
// Pipelined restoring divider: one quotient bit of (num * 2^FB) / den per stage.
module ppit_div
  import ppit_pkg::*;
(
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [MW-1:0] num_i,
  input  logic [MW-1:0] den_i,
  output logic [QW-1:0] quot_o,
  output logic          ovf_o
);

  logic [MW-1:0] rem_q  [0:QW];
  logic [QW-1:0] low_q  [0:QW];
  logic [MW-1:0] den_q  [0:QW];
  logic [QW-1:0] quot_q [0:QW];
  logic          ovf_q  [0:QW];

  // Entry stage: the quotient overflows QW bits when num >= den * 2^(QW-FB).
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= MW'(num_i[MW-1:QW-FB]);
      low_q[0]  <= {num_i[QW-FB-1:0], FB'(0)};
      den_q[0]  <= den_i;
      quot_q[0] <= '0;
      ovf_q[0]  <= {(QW-FB)'(0), num_i} >= {den_i, (QW-FB)'(0)};
    end
  end

  // One trial subtraction per stage.
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [MW:0] trial;
    logic        take;

    always_comb begin
      trial = {rem_q[k-1], low_q[k-1][QW-1]};
      take  = trial >= {1'b0, den_q[k-1]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? MW'(trial - {1'b0, den_q[k-1]}) : trial[MW-1:0];
        low_q[k]  <= {low_q[k-1][QW-2:0], 1'b0};
        den_q[k]  <= den_q[k-1];
        quot_q[k] <= {quot_q[k-1][QW-2:0], take};
        ovf_q[k]  <= ovf_q[k-1];
      end
    end
  end

  assign quot_o = quot_q[QW];
  assign ovf_o  = ovf_q[QW];

endmodule

FILE: src/ppit_back.sv
// Back pipeline: signed saturation of the quotients and the inside test.
module ppit_back
  import ppit_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [QW-1:0]         q_xi_i,
  input  logic                  ovf_xi_i,
  input  logic [QW-1:0]         q_eta_i,
  input  logic                  ovf_eta_i,
  input  ppit_side_t            side_i,
  input  logic [MGW-1:0]        margin_i,
  output logic [CW-1:0]         xi_o,
  output logic [CW-1:0]         eta_o,
  output logic [CW-1:0]         wrap_x_o,
  output logic [CW-1:0]         wrap_y_o,
  output logic                  inside_o,
  output logic                  degen_o
);

  localparam logic [QW-1:0] MinMag = {1'b1, (QW-1)'(0)};
  localparam logic [CW-1:0] MaxPos = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MinNeg = {1'b1, (CW-1)'(0)};

  // Saturate a magnitude with its sign to the signed coordinate range.
  function automatic logic [CW-1:0] sat_coord(logic [QW-1:0] q, logic ovf, logic neg);
    logic [CW-1:0] r;
    if (neg) begin
      r = (ovf || q > MinMag) ? MinNeg : CW'(-q);
    end else begin
      r = (ovf || q[QW-1]) ? MaxPos : q;
    end
    return r;
  endfunction

  // Stage 1: saturation; a zero determinant forces both coordinates to zero.
  logic [CW-1:0] xi_q, eta_q, wx_q, wy_q;
  logic          degen_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xi_q    <= side_i.degen ? '0 : sat_coord(q_xi_i, ovf_xi_i, side_i.neg_xi);
      eta_q   <= side_i.degen ? '0 : sat_coord(q_eta_i, ovf_eta_i, side_i.neg_eta);
      wx_q    <= side_i.wrap_x;
      wy_q    <= side_i.wrap_y;
      degen_q <= side_i.degen;
    end
  end

  // Stage 2: edge tests against the margin.
  logic signed [CW+1:0] xi_s, eta_s, m_s, sum_s;
  logic                 inside_d;

  always_comb begin
    xi_s     = $signed({{2{xi_q[CW-1]}}, xi_q});
    eta_s    = $signed({{2{eta_q[CW-1]}}, eta_q});
    m_s      = $signed({(CW+2-MGW)'(0), margin_i});
    sum_s    = xi_s + eta_s - $signed((CW+2)'(1) << FB);
    inside_d = !degen_q && (xi_s >= -m_s) && (eta_s >= -m_s) && (sum_s <= m_s);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xi_o     <= xi_q;
      eta_o    <= eta_q;
      wrap_x_o <= wx_q;
      wrap_y_o <= wy_q;
      inside_o <= inside_d;
      degen_o  <= degen_q;
    end
  end

endmodule

FILE: src/periodic_point_in_triangle_top.sv
// Top level of the periodic point-in-triangle block with its configuration registers.
//
// Usage:
//   The slave stream carries one query per transfer: a point and three triangle
//   vertices. The master stream returns one result per query, in order: the
//   natural coordinates xi and eta, the point after the periodic shift, and the
//   inside and degenerate flags. Configuration writes set the box lengths and
//   the inside margin; they are accepted in every cycle and must only be issued
//   while no query is in flight.
// Stages and throughput:
//   A query passes 5 front stages (offsets, shift, products, determinant,
//   magnitudes), 33 divider stages (entry, then a quotient bit each) and 2
//   back stages. One query per cycle is accepted while no result is held.
// Reset:
//   The pipeline empties, the box lengths become 1.0 and the margin becomes 0.
// Stall:
//   While a result waits on the master side, the whole pipeline holds and the
//   slave side is not ready; nothing is lost or repeated.
module periodic_point_in_triangle_top
  import ppit_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // point_x, point_y, vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // xi_coord, eta_coord, wrapped_x, wrapped_y
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // inside_res, degenerate
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  // Configuration registers.
  logic [BW-1:0]  box_x_q, box_y_q;
  logic [MGW-1:0] margin_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q  <= BW'(1) << FB;
      box_y_q  <= BW'(1) << FB;
      margin_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_BOX_X:  box_x_q  <= cfg_data_i[BW-1:0];
        REG_BOX_Y:  box_y_q  <= cfg_data_i[BW-1:0];
        REG_MARGIN: margin_q <= cfg_data_i[MGW-1:0];
        default:    ;
      endcase
    end
  end

  // The whole pipeline advances unless a result is held at the output.
  logic                en;
  logic [PIPE_LAT-1:0] vld_q;

  assign en            = !vld_q[PIPE_LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  // Front stages.
  logic [MW-1:0] mag_xi, mag_eta, mag_det;
  ppit_side_t    side_front;

  ppit_front u_front (
    .clk_i     (clk_i),
    .en_i      (en),
    .px_i      (s_axis_tdata[0*CW +: CW]),
    .py_i      (s_axis_tdata[1*CW +: CW]),
    .x0_i      (s_axis_tdata[2*CW +: CW]),
    .y0_i      (s_axis_tdata[3*CW +: CW]),
    .x1_i      (s_axis_tdata[4*CW +: CW]),
    .y1_i      (s_axis_tdata[5*CW +: CW]),
    .x2_i      (s_axis_tdata[6*CW +: CW]),
    .y2_i      (s_axis_tdata[7*CW +: CW]),
    .lx_i      (box_x_q),
    .ly_i      (box_y_q),
    .mag_xi_o  (mag_xi),
    .mag_eta_o (mag_eta),
    .mag_det_o (mag_det),
    .side_o    (side_front)
  );

  // Two dividers run side by side.
  logic [QW-1:0] q_xi, q_eta;
  logic          ovf_xi, ovf_eta;

  ppit_div u_div_xi (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (mag_xi),
    .den_i  (mag_det),
    .quot_o (q_xi),
    .ovf_o  (ovf_xi)
  );

  ppit_div u_div_eta (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (mag_eta),
    .den_i  (mag_det),
    .quot_o (q_eta),
    .ovf_o  (ovf_eta)
  );

  // Side values delayed to line up with the quotients.
  ppit_side_t side_q [0:DIV_LAT-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_front;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Back stages, ending in the output register.
  logic [CW-1:0] xi, eta, wx, wy;
  logic          inside_flag, degen;

  ppit_back u_back (
    .clk_i     (clk_i),
    .en_i      (en),
    .q_xi_i    (q_xi),
    .ovf_xi_i  (ovf_xi),
    .q_eta_i   (q_eta),
    .ovf_eta_i (ovf_eta),
    .side_i    (side_q[DIV_LAT-1]),
    .margin_i  (margin_q),
    .xi_o      (xi),
    .eta_o     (eta),
    .wrap_x_o  (wx),
    .wrap_y_o  (wy),
    .inside_o  (inside_flag),
    .degen_o   (degen)
  );

  assign m_axis_tdata = {wy, wx, eta, xi};
  assign m_axis_tuser = {degen, inside_flag};

endmodule

FILE: src/ppit_checker.sv
// Port-level checks for the periodic point-in-triangle block, bound to its top level.
module ppit_checker
  import ppit_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A degenerate triangle gives zero coordinates and is never inside.
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] == 1'b0
      && m_axis_tdata[2*CW-1:0] == '0)
    else $error("degenerate result with nonzero coordinates");

  // The input side is ready exactly when the output is free to move.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output state");

  // No result is shown in the cycle after reset is seen asserted.
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind periodic_point_in_triangle_top ppit_checker u_ppit_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb_periodic_point_in_triangle_top.sv
// Testbench for the periodic point-in-triangle block: directed and random queries checked by a predictor.
module tb_periodic_point_in_triangle_top
  import ppit_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [CW-1:0] px, py, x0, y0, x1, y1, x2, y2;
  } query_t;

  typedef struct {
    logic [CW-1:0] xi, eta, wx, wy;
    logic          in_tri, degen;
  } answer_t;

  typedef struct {
    query_t  q;
    bit      typed;
    answer_t a;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_index_i = REG_NONE;
  logic [31:0]            cfg_data_i = '0;

  // Shadow copy of the configuration registers.
  logic [BW-1:0]  box_x = 31'd65536;
  logic [BW-1:0]  box_y = 31'd65536;
  logic [MGW-1:0] margin = '0;

  answer_t pending_answers[$];
  int      errors = 0;
  bit      calm = 1'b0;   // no idling on either side while set
  int      stall_left = 0;
  row_t    rows[$];

  periodic_point_in_triangle_top uut (.*);

  always #5 clk_i = ~clk_i;

  // Saturated (num * 2^FB) / den, truncated toward zero.
  function automatic logic [CW-1:0] scaled_div(logic signed [129:0] num,
                                               logic signed [129:0] den);
    logic [129:0] mn, md, q;
    bit neg;
    neg = num[129] != den[129];
    mn = num[129] ? -num : num;
    md = den[129] ? -den : den;
    q = (mn << FB) / md;
    if (neg) begin
      if (q > 130'h80000000) return 32'h80000000;
      return -q[CW-1:0];
    end
    if (q > 130'h7FFFFFFF) return 32'h7FFFFFFF;
    return q[CW-1:0];
  endfunction

  // Minimum image shift, natural coordinates and the inside test.
  function automatic answer_t locate_point(query_t q);
    longint px, py, rx, ry, lx, ly, m, xi, eta;
    logic signed [129:0] ax, ay, bx, by, sx, sy, det, nxi, neta;
    answer_t a;
    px = q.px; py = q.py;
    lx = box_x; ly = box_y; m = margin;
    rx = px - longint'(q.x0); ry = py - longint'(q.y0);
    if (2 * rx >= lx) begin px -= lx; rx -= lx; end
    else if (2 * rx < -lx) begin px += lx; rx += lx; end
    if (2 * ry >= ly) begin py -= ly; ry -= ly; end
    else if (2 * ry < -ly) begin py += ly; ry += ly; end
    ax = longint'(q.x1) - longint'(q.x0);
    ay = longint'(q.y1) - longint'(q.y0);
    bx = longint'(q.x2) - longint'(q.x0);
    by = longint'(q.y2) - longint'(q.y0);
    sx = rx; sy = ry;
    det = ax * by - bx * ay;
    a.wx = px[CW-1:0];
    a.wy = py[CW-1:0];
    a.degen = det == 0;
    a.xi = '0; a.eta = '0; a.in_tri = 1'b0;
    if (!a.degen) begin
      nxi = by * sx - bx * sy;
      neta = ax * sy - ay * sx;
      a.xi = scaled_div(nxi, det);
      a.eta = scaled_div(neta, det);
      xi = longint'(signed'(a.xi));
      eta = longint'(signed'(a.eta));
      a.in_tri = xi >= -m && eta >= -m && xi + eta - (64'sd1 <<< FB) <= m;
    end
    return a;
  endfunction

  // Offer one query; returns at the falling edge after its transfer.
  task automatic send_query(query_t q, bit typed, answer_t a);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {q.y2, q.x2, q.y1, q.x1, q.y0, q.x0, q.py, q.px};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_answers.push_back(typed ? a : locate_point(q));
    @(negedge clk_i);
  endtask

  // Register write while the pipeline is empty.
  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    wait (pending_answers.size() == 0);
    repeat (PIPE_LAT + 5) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_BOX_X:  box_x = value[BW-1:0];
      REG_BOX_Y:  box_y = value[BW-1:0];
      REG_MARGIN: margin = value[MGW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic query_t make_query(int px, int py, int x0, int y0,
                                        int x1, int y1, int x2, int y2);
    query_t q;
    q.px = px; q.py = py; q.x0 = x0; q.y0 = y0;
    q.x1 = x1; q.y1 = y1; q.x2 = x2; q.y2 = y2;
    return q;
  endfunction

  // Random query: mostly small triangles near the point, some collinear, some raw noise.
  function automatic query_t random_query();
    query_t q;
    int kind, span, k;
    kind = $urandom_range(0, 9);
    span = 1 << $urandom_range(8, 20);
    if (kind < 2) begin
      q = make_query($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
    end else begin
      q.x0 = $urandom; q.y0 = $urandom;
      if (kind == 2) begin
        q.x0 = $urandom_range(0, 1 << 20) - (1 << 19);
        q.y0 = $urandom_range(0, 1 << 20) - (1 << 19);
      end
      q.x1 = q.x0 + $signed($urandom_range(0, 2 * span)) - span;
      q.y1 = q.y0 + $signed($urandom_range(0, 2 * span)) - span;
      if (kind == 3) begin
        k = $signed($urandom_range(0, 6)) - 3;
        q.x2 = q.x0 + k * (q.x1 - q.x0);
        q.y2 = q.y0 + k * (q.y1 - q.y0);
      end else begin
        q.x2 = q.x0 + $signed($urandom_range(0, 2 * span)) - span;
        q.y2 = q.y0 + $signed($urandom_range(0, 2 * span)) - span;
      end
      q.px = q.x0 + $signed($urandom_range(0, 2 * span)) - span / 2;
      q.py = q.y0 + $signed($urandom_range(0, 2 * span)) - span / 2;
      if (kind == 4) begin
        q.px = q.x0 + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        q.py = q.y0 + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      end
    end
    return q;
  endfunction

  // Receiver stalls, redrawn after each result transfer.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest pending answer.
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      stall_left <= calm ? 0 : $urandom_range(0, 4);
      if (pending_answers.size() == 0) begin
        $error("result with no query outstanding");
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (m_axis_tdata[31:0] !== e.xi) begin
          $error("xi_coord: expected %h, got %h", e.xi, m_axis_tdata[31:0]); errors++;
        end
        if (m_axis_tdata[63:32] !== e.eta) begin
          $error("eta_coord: expected %h, got %h", e.eta, m_axis_tdata[63:32]); errors++;
        end
        if (m_axis_tdata[95:64] !== e.wx) begin
          $error("wrapped_x: expected %h, got %h", e.wx, m_axis_tdata[95:64]); errors++;
        end
        if (m_axis_tdata[127:96] !== e.wy) begin
          $error("wrapped_y: expected %h, got %h", e.wy, m_axis_tdata[127:96]); errors++;
        end
        if (m_axis_tuser[0] !== e.in_tri) begin
          $error("inside_res: expected %b, got %b", e.in_tri, m_axis_tuser[0]); errors++;
        end
        if (m_axis_tuser[1] !== e.degen) begin
          $error("degenerate: expected %b, got %b", e.degen, m_axis_tuser[1]); errors++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus.
  initial begin
    row_t r;
    answer_t none;
    none = '{default: '0};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed queries under the reset configuration.
    r.typed = 1'b1;
    r.q = make_query(0, 0, 0, 0, 0, 0, 0, 0);
    r.a = '{xi: 0, eta: 0, wx: 0, wy: 0, in_tri: 0, degen: 1};
    rows.push_back(r);
    r.q = make_query(16384, 16384, 0, 0, 65536, 0, 0, 65536);
    r.a = '{xi: 16384, eta: 16384, wx: 16384, wy: 16384, in_tri: 1, degen: 0};
    rows.push_back(r);
    r.q = make_query(0, 0, 0, 0, 65536, 0, 0, 65536);
    r.a = '{xi: 0, eta: 0, wx: 0, wy: 0, in_tri: 1, degen: 0};
    rows.push_back(r);
    r.typed = 1'b0;
    r.a = none;
    rows.push_back('{make_query(65536, 0, 0, 0, 65536, 0, 0, 65536), 0, none});
    rows.push_back('{make_query(-32768, -32769, 0, 0, 65536, 0, 0, 65536), 0, none});
    rows.push_back('{make_query(32767, 32768, 0, 0, 65536, 0, 0, 65536), 0, none});
    rows.push_back('{make_query(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000),
                     0, none});
    rows.push_back('{make_query(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF),
                     0, none});
    rows.push_back('{make_query(32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 1, 0, 0, 1), 0, none});
    rows.push_back('{make_query(30000, 30000, 0, 0, 1, 0, 0, 1), 0, none});
    rows.push_back('{make_query(-30000, 20000, 0, 0, -1, 0, 0, -1), 0, none});
    rows.push_back('{make_query(5, 7, 0, 0, 2, 4, 1, 2), 0, none});
    rows.push_back('{make_query(100, 200, 10, 20, 10, 20, 300, 400), 0, none});
    rows.push_back('{make_query(0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000),
                     0, none});
    rows.push_back('{make_query(32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555,
                                32'h12345678, 32'h9ABCDEF0, 32'hFEDCBA98, 32'h76543210),
                     0, none});
    rows.push_back('{make_query(40000, -40000, 0, 0, 0, 65536, 65536, 0), 0, none});
    foreach (rows[i]) send_query(rows[i].q, rows[i].typed, rows[i].a);

    // Random queries across several configurations.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_BOX_X, 32'h7FFFFFFF);
          write_reg(REG_BOX_Y, 32'h7FFFFFFF);
          write_reg(REG_MARGIN, 32'h0000FFFF);
        end
        2: begin
          write_reg(REG_BOX_X, 32'd1);
          write_reg(REG_BOX_Y, 32'd1);
          write_reg(REG_MARGIN, 32'd0);
        end
        3: begin
          // Zero box length leaves the point where it is.
          write_reg(REG_BOX_X, 32'd0);
          write_reg(REG_BOX_Y, 32'd0);
          write_reg(REG_MARGIN, 32'd655);
        end
        4: begin
          // Upper data bits beyond each register are dropped.
          write_reg(REG_BOX_X, 32'h800A0000);
          write_reg(REG_BOX_Y, 32'hFFF80000);
          write_reg(REG_MARGIN, 32'hFFFF1000);
        end
        5: write_reg(REG_NONE, 32'hFFFFFFFF);
        6: begin
          write_reg(REG_BOX_X, $urandom_range(1, 1 << 22));
          write_reg(REG_BOX_Y, $urandom_range(1, 1 << 22));
          write_reg(REG_MARGIN, $urandom_range(0, 65535));
        end
        default: ;
      endcase
      for (int n = 0; n < 110; n++) begin
        calm = (n >= 50 && n < 70);
        send_query(random_query(), 1'b0, none);
      end
      calm = 1'b0;
    end
    s_axis_tvalid <= 1'b0;

    wait (pending_answers.size() == 0);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
